### design/spv_pkg.sv
`timescale 1ns / 1ps

package spv_pkg;

    localparam int MIX_W    = 24;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1 - 16;

    // item function codes
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_TRIG   = 2'd1;
    localparam logic [1:0] FUNC_CUT    = 2'd2;
    localparam logic [1:0] FUNC_RENDER = 2'd3;

    // register indexes (byte address is 4x)
    localparam logic [2:0] REG_STEP_RATE    = 3'd0;
    localparam logic [2:0] REG_LOOP_ENABLE  = 3'd1;
    localparam logic [2:0] REG_WAVE_LENGTH  = 3'd2;
    localparam logic [2:0] REG_LOOP_BEGIN   = 3'd3;
    localparam logic [2:0] REG_LOOP_FINISH  = 3'd4;
    localparam logic [2:0] REG_GAIN_LEVEL   = 3'd5;
    localparam logic [2:0] REG_PAN_POSITION = 3'd6;

    localparam logic [23:0] RST_STEP_RATE    = 24'd65536;
    localparam logic [7:0]  RST_GAIN_LEVEL   = 8'd128;
    localparam logic [8:0]  RST_PAN_POSITION = 9'd128;

    localparam logic [7:0]  VOL_MAX = 8'd128;
    localparam logic [8:0]  PAN_MAX = 9'd256;

    typedef struct packed {
        logic [1:0]           func;
        logic [13:0]          wave_addr;
        logic signed [15:0]   wave_left;
        logic signed [15:0]   wave_right;
        logic [13:0]          start_frame;
        logic signed [23:0]   mix_in_left;
        logic signed [23:0]   mix_in_right;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0]   mix_out_left;
        logic signed [23:0]   mix_out_right;
        logic                 voice_active;
    } t_out_item;

    typedef struct packed {
        logic [23:0] step_rate;
        logic        loop_enable;
        logic [14:0] wave_length;
        logic [13:0] loop_begin;
        logic [14:0] loop_finish;
        logic [7:0]  gain_level;
        logic [8:0]  pan_position;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic cap;        // capture the accepted request
        logic wr_wave;
        logic trig;
        logic cut;        // note off
        logic kill;       // this render adds nothing
        logic mod_start;
        logic mod_step;
        logic rd;
        logic mul;
        logic acc;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] func;
        logic       note;
        logic       render;
        logic       loop_en;
        logic       need_wrap;
        logic       loop_empty;
        logic       past_len;
        logic       mod_last;
        logic       out_busy;
    } t_status;

endpackage

### design/spv_ram.sv
`timescale 1ns / 1ps

module spv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/spv_ctrl.sv
`timescale 1ns / 1ps

module spv_ctrl import spv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_MOD1 = 4'd2;
    localparam logic [3:0] S_READ = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_CHK2 = 4'd6;
    localparam logic [3:0] S_MOD2 = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_status.func)
                    FUNC_WRITE: begin
                        o_cmd.wr_wave = 1'b1;
                        n_state       = S_FIN;
                    end
                    FUNC_TRIG: begin
                        o_cmd.trig = 1'b1;
                        n_state    = S_FIN;
                    end
                    FUNC_CUT: begin
                        o_cmd.cut = 1'b1;
                        n_state   = S_FIN;
                    end
                    default: begin
                        if (!i_status.note) begin
                            o_cmd.kill = 1'b1;
                            n_state    = S_ACC;
                        end else if (i_status.loop_en) begin
                            if (!i_status.need_wrap) begin
                                n_state = S_READ;
                            end else if (i_status.loop_empty) begin
                                o_cmd.cut  = 1'b1;
                                o_cmd.kill = 1'b1;
                                n_state    = S_ACC;
                            end else begin
                                o_cmd.mod_start = 1'b1;
                                n_state         = S_MOD1;
                            end
                        end else if (i_status.past_len) begin
                            o_cmd.cut  = 1'b1;
                            o_cmd.kill = 1'b1;
                            n_state    = S_ACC;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                endcase
            end
            S_MOD1: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CHK2;
            end
            S_CHK2: begin
                n_state = S_FIN;
                if (i_status.render) begin
                    if (i_status.loop_en) begin
                        if (i_status.need_wrap) begin
                            if (i_status.loop_empty) begin
                                o_cmd.cut = 1'b1;
                            end else begin
                                o_cmd.mod_start = 1'b1;
                                n_state         = S_MOD2;
                            end
                        end
                    end else if (i_status.past_len) begin
                        o_cmd.cut = 1'b1;
                    end
                end
            end
            S_MOD2: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### design/spv_dp.sv
`timescale 1ns / 1ps

module spv_dp import spv_pkg::*; #(
    parameter int WAVE_DEPTH = 16384,
    parameter int FRAC_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IW    = POS_W - FRAC_BITS;   // integer bits of the position
    localparam int AW    = $clog2(WAVE_DEPTH);
    localparam int CNT_W = $clog2(IW);

    function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [MIX_W:0] v);
        logic signed [MIX_W:0] hi;
        logic signed [MIX_W:0] lo;
        hi = (MIX_W+1)'(2 ** (MIX_W - 1) - 1);
        lo = -(MIX_W+1)'(2 ** (MIX_W - 1));
        if (v > hi) begin
            return hi[MIX_W-1:0];
        end else if (v < lo) begin
            return lo[MIX_W-1:0];
        end
        return v[MIX_W-1:0];
    endfunction

    t_in_item                  r_item;
    logic [POS_W-1:0]          r_pos;
    logic                      r_note;
    logic                      r_render;
    logic [GAIN_W-1:0]         r_gain_l;
    logic [GAIN_W-1:0]         r_gain_r;
    logic [14:0]               r_rem;
    logic [IW-1:0]             r_quo;
    logic [FRAC_BITS-1:0]      r_frac;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_oob;
    logic signed [PROD_W-1:0]  r_prod_l;
    logic signed [PROD_W-1:0]  r_prod_r;
    logic signed [MIX_W-1:0]   r_res_l;
    logic signed [MIX_W-1:0]   r_res_r;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [POS_W-1:0]          w_loop_end;
    logic [POS_W-1:0]          w_base;
    logic [POS_W-1:0]          w_wave_end;
    logic [POS_W-1:0]          w_off;
    logic [POS_W-1:0]          w_wrap_pos;
    logic [14:0]               w_loop_len;
    logic [15:0]               w_rem_sh;
    logic [15:0]               w_rem_sub;
    logic [14:0]               w_rem_nx;
    logic [IW-1:0]             w_idx;
    logic [7:0]                w_vol;
    logic [8:0]                w_pan;
    logic [GAIN_W:0]           w_gain_l;
    logic [GAIN_W:0]           w_gain_r;
    logic signed [SAMPLE_W-1:0] w_s_l;
    logic signed [SAMPLE_W-1:0] w_s_r;
    logic signed [SAMPLE_W+GAIN_W:0] w_mul_l;
    logic signed [SAMPLE_W+GAIN_W:0] w_mul_r;
    logic signed [MIX_W:0]     w_add_l;
    logic signed [MIX_W:0]     w_add_r;
    logic signed [MIX_W:0]     w_sum_l;
    logic signed [MIX_W:0]     w_sum_r;
    logic                      w_wr_ok;
    logic                      w_ram_en;
    logic [AW-1:0]             w_ram_addr;
    logic [2*SAMPLE_W-1:0]     w_ram_rdata;

    // position bounds in Q format
    assign w_loop_end = POS_W'(i_cfg.loop_finish) << FRAC_BITS;
    assign w_base     = POS_W'(i_cfg.loop_begin) << FRAC_BITS;
    assign w_wave_end = POS_W'(i_cfg.wave_length) << FRAC_BITS;
    assign w_loop_len = i_cfg.loop_finish - 15'(i_cfg.loop_begin);
    assign w_off      = r_pos - w_base;

    // restoring remainder, one quotient bit per cycle; fraction bits ride along
    assign w_rem_sh   = {r_rem, r_quo[IW-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, w_loop_len};
    assign w_rem_nx   = (w_rem_sh >= {1'b0, w_loop_len}) ? w_rem_sub[14:0] : w_rem_sh[14:0];
    assign w_wrap_pos = ((POS_W'(i_cfg.loop_begin) + POS_W'(w_rem_nx)) << FRAC_BITS)
                        | POS_W'(r_frac);

    assign w_idx = r_pos[POS_W-1:FRAC_BITS];

    assign w_vol    = (i_cfg.gain_level > VOL_MAX) ? VOL_MAX : i_cfg.gain_level;
    assign w_pan    = (i_cfg.pan_position > PAN_MAX) ? PAN_MAX : i_cfg.pan_position;
    assign w_gain_l = {9'd0, w_vol} * {8'd0, PAN_MAX - w_pan};
    assign w_gain_r = {9'd0, w_vol} * {8'd0, w_pan};

    assign w_s_l   = r_oob ? '0 : $signed(w_ram_rdata[SAMPLE_W-1:0]);
    assign w_s_r   = r_oob ? '0 : $signed(w_ram_rdata[2*SAMPLE_W-1:SAMPLE_W]);
    assign w_mul_l = w_s_l * $signed({1'b0, r_gain_l});
    assign w_mul_r = w_s_r * $signed({1'b0, r_gain_r});

    assign w_add_l = r_render ? (MIX_W+1)'(r_prod_l) : '0;
    assign w_add_r = r_render ? (MIX_W+1)'(r_prod_r) : '0;
    assign w_sum_l = (MIX_W+1)'(r_item.mix_in_left) + w_add_l;
    assign w_sum_r = (MIX_W+1)'(r_item.mix_in_right) + w_add_r;

    assign w_wr_ok    = (33'(r_item.wave_addr) < 33'(WAVE_DEPTH));
    assign w_ram_en   = (i_cmd.wr_wave && w_wr_ok) || i_cmd.rd;
    assign w_ram_addr = i_cmd.wr_wave ? AW'(r_item.wave_addr) : AW'(w_idx);

    spv_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (WAVE_DEPTH)
    ) u_wave (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (i_cmd.wr_wave),
        .i_addr  (w_ram_addr),
        .i_wdata ({r_item.wave_right, r_item.wave_left}),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_note      <= 1'b0;
            r_render    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_render <= 1'b1;
            end else if (i_cmd.kill) begin
                r_render <= 1'b0;
            end

            if (i_cmd.trig) begin
                r_note <= 1'b1;
            end else if (i_cmd.cut) begin
                r_note <= 1'b0;
            end

            if (i_cmd.trig) begin
                r_pos <= POS_W'(r_item.start_frame) << FRAC_BITS;
            end else if (i_cmd.mod_step && (r_cnt == '0)) begin
                r_pos <= w_wrap_pos;
            end else if (i_cmd.acc && r_render) begin
                r_pos <= r_pos + POS_W'(i_cfg.step_rate);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain_l <= w_gain_l[GAIN_W-1:0];
        r_gain_r <= w_gain_r[GAIN_W-1:0];
        if (i_cmd.cap) begin
            r_item <= i_in_data;
        end
        if (i_cmd.mod_start) begin
            r_rem  <= '0;
            r_quo  <= w_off[POS_W-1:FRAC_BITS];
            r_frac <= w_off[FRAC_BITS-1:0];
            r_cnt  <= CNT_W'(IW - 1);
        end else if (i_cmd.mod_step) begin
            r_rem <= w_rem_nx;
            r_quo <= r_quo << 1;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.rd) begin
            r_oob <= (33'(w_idx) >= 33'(WAVE_DEPTH));
        end
        if (i_cmd.mul) begin
            // floor shift by 16 keeps the top bits
            r_prod_l <= w_mul_l[SAMPLE_W+GAIN_W:16];
            r_prod_r <= w_mul_r[SAMPLE_W+GAIN_W:16];
        end
        if (i_cmd.acc) begin
            r_res_l <= sat_mix(w_sum_l);
            r_res_r <= sat_mix(w_sum_r);
        end
        if (i_cmd.out_load) begin
            r_out.mix_out_left  <= (r_item.func == FUNC_RENDER) ? r_res_l : '0;
            r_out.mix_out_right <= (r_item.func == FUNC_RENDER) ? r_res_r : '0;
            r_out.voice_active  <= r_note;
        end
    end

    always_comb begin
        o_status.func       = r_item.func;
        o_status.note       = r_note;
        o_status.render     = r_render;
        o_status.loop_en    = i_cfg.loop_enable;
        o_status.need_wrap  = (r_pos >= w_loop_end);
        o_status.loop_empty = (i_cfg.loop_finish <= 15'(i_cfg.loop_begin));
        o_status.past_len   = (r_pos >= w_wave_end);
        o_status.mod_last   = (r_cnt == '0);
        o_status.out_busy   = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### design/sample_playback_voice.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   t_in_item  (func, wave, trigger, mix in)
// out       output     o_out_valid / i_out_stall t_out_item (mix out, voice_active)
// config    input      APB psel/penable/pwrite   7 registers at 4*index
//
// Write, trigger and cut: the request passes dispatch, then finish, where the result is loaded.
// Render: dispatch, read, multiply, accumulate, check, finish (no read or multiply when silent or
// stopped before the read) plus a remainder pass per loop wrap, at most two; it retires one bit a cycle.
// One request in flight; the next is accepted while a result waits in the output register,
// and a finished result holds the controller while the previous one is still stalled.
// Synchronous active-low reset clears control and config; wave RAM is not cleared.
module sample_playback_voice import spv_pkg::*; #(
    parameter int WAVE_DEPTH = 16384,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_rate    <= RST_STEP_RATE;
            r_cfg.loop_enable  <= 1'b0;
            r_cfg.wave_length  <= '0;
            r_cfg.loop_begin   <= '0;
            r_cfg.loop_finish  <= '0;
            r_cfg.gain_level   <= RST_GAIN_LEVEL;
            r_cfg.pan_position <= RST_PAN_POSITION;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_STEP_RATE:    r_cfg.step_rate    <= pwdata[23:0];
                REG_LOOP_ENABLE:  r_cfg.loop_enable  <= pwdata[0];
                REG_WAVE_LENGTH:  r_cfg.wave_length  <= pwdata[14:0];
                REG_LOOP_BEGIN:   r_cfg.loop_begin   <= pwdata[13:0];
                REG_LOOP_FINISH:  r_cfg.loop_finish  <= pwdata[14:0];
                REG_GAIN_LEVEL:   r_cfg.gain_level   <= pwdata[7:0];
                REG_PAN_POSITION: r_cfg.pan_position <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_STEP_RATE:    prdata = 32'(r_cfg.step_rate);
            REG_LOOP_ENABLE:  prdata = 32'(r_cfg.loop_enable);
            REG_WAVE_LENGTH:  prdata = 32'(r_cfg.wave_length);
            REG_LOOP_BEGIN:   prdata = 32'(r_cfg.loop_begin);
            REG_LOOP_FINISH:  prdata = 32'(r_cfg.loop_finish);
            REG_GAIN_LEVEL:   prdata = 32'(r_cfg.gain_level);
            REG_PAN_POSITION: prdata = 32'(r_cfg.pan_position);
            default:          prdata = '0;
        endcase
    end

    spv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    spv_dp #(
        .WAVE_DEPTH (WAVE_DEPTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### design/spv_checker.sv
`timescale 1ns / 1ps

module spv_checker import spv_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [1:0] r_pend;    // requests accepted but not yet delivered

    assign w_in_acc  = i_in_valid && !i_in_stall;
    assign w_out_acc = i_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_in_acc && w_out_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> i_in_stall)
        else $error("second request taken while one is in work");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3 && (i_out_valid || r_pend <= 2'd1))
        else $error("too many requests outstanding");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without a request");

endmodule

bind sample_playback_voice spv_checker u_spv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
